### rtl/ecpb_pkg.sv
// Shared types, codes and the color hash for the exact color palette builder.
package ecpb_pkg;

  localparam int unsigned IDX_W = 8;
  localparam int unsigned RGB_W = 24;

  localparam logic [RGB_W-1:0] TRANSP_RGB   = 24'hFF_FFFF;
  localparam logic [7:0]       ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALPHA   = 2'd1,
    ST_FULL    = 2'd2,
    ST_EARLIER = 2'd3
  } ecpb_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_CHECK,
    S_EMIT
  } ecpb_state_t;

  // Write request into the hash table.
  typedef struct packed {
    logic             en;
    logic [RGB_W-1:0] color;
    logic [IDX_W-1:0] index;
  } ecpb_tbl_wr_t;

  // Fold the RGB value into a byte; callers keep the low bits they need.
  function automatic logic [7:0] ecpb_hash(input logic [RGB_W-1:0] c);
    logic [7:0] h;
    h = c[7:0] ^ c[15:8] ^ c[23:16] ^ {c[20:16], c[23:21]};
    return h;
  endfunction

endpackage

### rtl/ecpb_if.sv
// Channel interfaces: pixel input, result output and configuration write.
interface ecpb_in_if;
  logic        valid;
  logic        ready;
  logic        start_image;
  logic [31:0] pixel_argb;

  modport source (output valid, output start_image, output pixel_argb, input ready);
  modport sink   (input valid, input start_image, input pixel_argb, output ready);
endinterface

interface ecpb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  color_index;
  logic [1:0]  status;
  logic        added_entry;
  logic [23:0] added_color;
  logic        added_is_transparent;

  modport source (output valid, output color_index, output status, output added_entry,
                  output added_color, output added_is_transparent, input ready);
  modport sink   (input valid, input color_index, input status, input added_entry,
                  input added_color, input added_is_transparent, output ready);
endinterface

interface ecpb_cfg_if;
  logic valid;
  logic ready;
  logic ignore_transparent;

  modport source (output valid, output ignore_transparent, input ready);
  modport sink   (input valid, input ignore_transparent, output ready);
endinterface

### rtl/ecpb_table.sv
// Open-addressed color table: one synchronous memory plus per-slot valid flops.
module ecpb_table #(
  parameter int unsigned TW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic [TW-1:0]         rd_addr,
  input  logic [TW-1:0]         wr_addr,
  input  ecpb_pkg::ecpb_tbl_wr_t wr,
  output logic                  rd_valid,
  output logic [23:0]           rd_color,
  output logic [7:0]            rd_index
);
  import ecpb_pkg::*;

  localparam int unsigned TS = 1 << TW;

  logic [RGB_W+IDX_W-1:0] mem [TS];
  logic [TS-1:0]          valid_r;
  logic [RGB_W+IDX_W-1:0] rd_data_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= {wr.color, wr.index};
    end
    rd_data_r  <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_color = rd_data_r[RGB_W+IDX_W-1:IDX_W];
  assign rd_index = rd_data_r[IDX_W-1:0];

  ap_no_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(clear && wr.en))
    else $error("table write during clear");
  ap_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> valid_r == '0)
    else $error("table not empty after clear");
  ap_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> valid_r[$past(wr_addr)])
    else $error("written slot not marked valid");

endmodule

### rtl/exact_color_palette_builder_top.sv
// Top level: request control, palette bookkeeping and the result register.
//
// Pixels arrive as requests on in_chan (start_image, pixel_argb); every pixel
// gives exactly one result on out_chan: color_index, status, and a report of
// any palette entry that the pixel created. cfg_chan writes ignore_transparent
// and is always ready; write it only while no pixel is in flight.
// Opaque colors are found in an open-addressed hash table held in one
// synchronous memory; each probe is a read state followed by a compare state.
// An accepted pixel passes a decide state, then one probe and a further
// probe per colliding slot (at most table size probes), then the emit
// state. Transparent, partial alpha and failed pixels skip the probes.
// One pixel is worked on at a time; the next request is taken as soon as
// the control returns to idle, even while the last result waits in the
// output register. When the receiver stalls, the finished result of the
// following pixel holds until the output register frees.
// Reset empties the palette, drops the transparent slot, clears any failure
// and sets ignore_transparent to 0. A start_image request clears the table
// in its acceptance cycle, with no clearing pass.
module exact_color_palette_builder_top #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic clk,
  input  logic rst_n,
  ecpb_in_if.sink    in_chan,
  ecpb_out_if.source out_chan,
  ecpb_cfg_if.sink   cfg_chan
);
  import ecpb_pkg::*;

  localparam int unsigned TW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int unsigned TS = 1 << TW;
  localparam int unsigned CW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(PALETTE_ENTRIES);

  ecpb_state_t state_r, state_nxt;

  logic              ignore_r;
  logic [31:0]       pix_r, pix_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              trans_vld_r, trans_vld_nxt;
  logic [IDX_W-1:0]  trans_idx_r, trans_idx_nxt;
  ecpb_status_t      fail_r, fail_nxt;
  logic [TW-1:0]     probe_addr_r, probe_addr_nxt;
  logic [TW-1:0]     probe_cnt_r, probe_cnt_nxt;

  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  ecpb_status_t      res_status_r, res_status_nxt;
  logic              res_add_r, res_add_nxt;
  logic [RGB_W-1:0]  res_color_r, res_color_nxt;
  logic              res_transp_r, res_transp_nxt;
  logic              act_fail_r, act_fail_nxt;
  logic              act_op_r, act_op_nxt;
  logic              act_tr_r, act_tr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r;
  ecpb_status_t      out_status_r;
  logic              out_add_r;
  logic [RGB_W-1:0]  out_color_r;
  logic              out_transp_r;

  logic              in_fire, out_free, emit_now, tbl_clear;
  logic              rd_valid;
  logic [RGB_W-1:0]  rd_color;
  logic [IDX_W-1:0]  rd_index;
  logic              hit, last_probe;
  logic [7:0]        alpha;
  logic [7:0]        hash_full;
  ecpb_tbl_wr_t      tbl_wr;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign emit_now  = (state_r == S_EMIT) && out_free;
  assign tbl_clear = in_fire && in_chan.start_image;
  assign alpha      = pix_r[31:24];
  assign hash_full  = ecpb_hash(pix_r[RGB_W-1:0]);
  assign hit        = rd_valid && (rd_color == pix_r[RGB_W-1:0]);
  assign last_probe = (probe_cnt_r == TW'(TS - 1));

  assign tbl_wr.en    = emit_now && act_op_r;
  assign tbl_wr.color = res_color_r;
  assign tbl_wr.index = res_idx_r;

  ecpb_table #(.TW(TW)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (tbl_clear),
    .rd_addr  (probe_addr_r),
    .wr_addr  (probe_addr_r),
    .wr       (tbl_wr),
    .rd_valid (rd_valid),
    .rd_color (rd_color),
    .rd_index (rd_index)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (fail_r == ST_OK && alpha == ALPHA_OPAQUE) state_nxt = S_READ;
        else state_nxt = S_EMIT;
      end
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (hit || !rd_valid || last_probe) state_nxt = S_EMIT;
        else state_nxt = S_READ;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and bookkeeping.
  always_comb begin
    pix_nxt        = pix_r;
    count_nxt      = count_r;
    trans_vld_nxt  = trans_vld_r;
    trans_idx_nxt  = trans_idx_r;
    fail_nxt       = fail_r;
    probe_addr_nxt = probe_addr_r;
    probe_cnt_nxt  = probe_cnt_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    res_add_nxt    = res_add_r;
    res_color_nxt  = res_color_r;
    res_transp_nxt = res_transp_r;
    act_fail_nxt   = act_fail_r;
    act_op_nxt     = act_op_r;
    act_tr_nxt     = act_tr_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pix_nxt = in_chan.pixel_argb;
          if (in_chan.start_image) begin
            count_nxt     = '0;
            trans_vld_nxt = 1'b0;
            fail_nxt      = ST_OK;
          end
        end
      end
      S_DECIDE: begin
        res_idx_nxt    = '0;
        res_status_nxt = ST_OK;
        res_add_nxt    = 1'b0;
        res_color_nxt  = '0;
        res_transp_nxt = 1'b0;
        act_fail_nxt   = 1'b0;
        act_op_nxt     = 1'b0;
        act_tr_nxt     = 1'b0;
        probe_addr_nxt = hash_full[TW-1:0];
        probe_cnt_nxt  = '0;
        if (fail_r != ST_OK) begin
          res_status_nxt = ST_EARLIER;
        end else if (alpha != ALPHA_CLEAR && alpha != ALPHA_OPAQUE) begin
          res_status_nxt = ST_ALPHA;
          act_fail_nxt   = 1'b1;
        end else if (alpha == ALPHA_CLEAR) begin
          if (ignore_r) begin
            res_idx_nxt = '0;
          end else if (trans_vld_r) begin
            res_idx_nxt = trans_idx_r;
          end else if (count_r == FULL_CNT) begin
            res_status_nxt = ST_FULL;
            act_fail_nxt   = 1'b1;
          end else begin
            res_idx_nxt    = IDX_W'(count_r);
            res_add_nxt    = 1'b1;
            res_color_nxt  = TRANSP_RGB;
            res_transp_nxt = 1'b1;
            act_tr_nxt     = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (hit) begin
          res_idx_nxt = rd_index;
        end else if (!rd_valid || last_probe) begin
          // Every slot holding a color implies the palette is full.
          if (count_r == FULL_CNT || rd_valid) begin
            res_status_nxt = ST_FULL;
            act_fail_nxt   = 1'b1;
          end else begin
            res_idx_nxt   = IDX_W'(count_r);
            res_add_nxt   = 1'b1;
            res_color_nxt = pix_r[RGB_W-1:0];
            act_op_nxt    = 1'b1;
          end
        end else begin
          probe_addr_nxt = probe_addr_r + 1'b1;
          probe_cnt_nxt  = probe_cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (act_fail_r) fail_nxt = res_status_r;
          if (act_op_r || act_tr_r) count_nxt = count_r + 1'b1;
          if (act_tr_r) begin
            trans_vld_nxt = 1'b1;
            trans_idx_nxt = res_idx_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ignore_r    <= 1'b0;
      count_r     <= '0;
      trans_vld_r <= 1'b0;
      fail_r      <= ST_OK;
      out_valid_r <= 1'b0;
      act_fail_r  <= 1'b0;
      act_op_r    <= 1'b0;
      act_tr_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      trans_vld_r <= trans_vld_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
      act_fail_r  <= act_fail_nxt;
      act_op_r    <= act_op_nxt;
      act_tr_r    <= act_tr_nxt;
      if (cfg_chan.valid && cfg_chan.ready) ignore_r <= cfg_chan.ignore_transparent;
    end
  end

  always_ff @(posedge clk) begin
    pix_r        <= pix_nxt;
    trans_idx_r  <= trans_idx_nxt;
    probe_addr_r <= probe_addr_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    res_add_r    <= res_add_nxt;
    res_color_r  <= res_color_nxt;
    res_transp_r <= res_transp_nxt;
    if (emit_now) begin
      out_idx_r    <= res_idx_r;
      out_status_r <= res_status_r;
      out_add_r    <= res_add_r;
      out_color_r  <= res_color_r;
      out_transp_r <= res_transp_r;
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.color_index          = out_idx_r;
  assign out_chan.status               = out_status_r;
  assign out_chan.added_entry          = out_add_r;
  assign out_chan.added_color          = out_color_r;
  assign out_chan.added_is_transparent = out_transp_r;

  ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("palette count beyond capacity");
  ap_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_idx_r == '0 && !out_add_r)
    else $error("failed result carries an index or entry");
  ap_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |-> count_r < FULL_CNT)
    else $error("insert into full palette");
  ap_emit_grows: assert property (@(posedge clk) disable iff (!rst_n)
    emit_now && (act_op_r || act_tr_r) |=> count_r == $past(count_r) + 1'b1)
    else $error("new entry did not advance count");

endmodule
